// File: sv/pfpm_pkg.sv
`timescale 1ns / 1ps
package pfpm_pkg;
    localparam int ScaleW = 40;
    localparam int DataW  = 32;

    localparam logic [1:0] REQ_PW   = 2'd0;
    localparam logic [1:0] REQ_CV   = 2'd1;
    localparam logic [1:0] REQ_EVAL = 2'd2;
    localparam logic [1:0] REQ_PUB  = 2'd3;

    localparam logic [2:0] REG_PW_SCALE  = 3'd0;
    localparam logic [2:0] REG_CUR_SCALE = 3'd1;
    localparam logic [2:0] REG_VOL_SCALE = 3'd2;
    localparam logic [2:0] REG_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_FRACTION  = 3'd4;
    localparam logic [2:0] REG_ABSOLUTE  = 3'd5;
    localparam logic [2:0] REG_MIN_POWER = 3'd6;
    localparam logic [2:0] REG_MODE      = 3'd7;

    typedef struct packed {
        logic              start;
        logic [ScaleW-1:0] dividend;
        logic [DataW-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DataW-1:0] value;
    } div_rsp_t;
endpackage

// File: sv/pfpm_divider.sv
`timescale 1ns / 1ps
module pfpm_divider
    import pfpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // restoring division, one quotient bit a cycle, saturated to 32 bits
    logic [ScaleW-1:0] quo_reg, quo_next;
    logic [DataW:0]    rem_reg, rem_next;
    logic [DataW-1:0]  den_reg, den_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DataW+1:0]  trial;
    logic [DataW:0]    shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DataW-1:0], quo_reg[ScaleW-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 6'(ScaleW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DataW+1])
            begin
                rem_next = trial[DataW:0];
                quo_next = {quo_reg[ScaleW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[ScaleW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = (den_reg == '0) ? '0 :
                       (quo_reg[ScaleW-1:DataW] != '0) ? '1 : quo_reg[DataW-1:0];
endmodule

// File: sv/pulse_frequency_power_meter_core.sv
`timescale 1ns / 1ps
// sequence: edge and publish requests go straight to the output state; evaluate runs the
// current/voltage, power and rule states, up to two divisions on the shared 40-bit radix-2 divider
// throughput: one request at a time, the next one taken the cycle after the result is taken
// reset: asynchronous active low, registers to spec defaults, timeout 1000000 us,
// select line in voltage mode, both channels skip their first edge
module pulse_frequency_power_meter_core
    import pfpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // req_type[1:0], time_us[33:2], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // select_current, published, power_value,
                                    // current_value, voltage_value, power_stale,
                                    // current_stale, zero pad
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [39:0]  cfg_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CV   = 3'd1; // current/voltage channel evaluation
    localparam logic [2:0] ST_CVW  = 3'd2; // wait for divider
    localparam logic [2:0] ST_PW   = 3'd3; // power channel evaluation
    localparam logic [2:0] ST_PWW  = 3'd4;
    localparam logic [2:0] ST_FRAC = 3'd5; // fraction rule
    localparam logic [2:0] ST_ABS  = 3'd6; // absolute rule
    localparam logic [2:0] ST_OUT  = 3'd7;

    // configuration
    logic [ScaleW-1:0] pw_scale_reg, cur_scale_reg, vol_scale_reg;
    logic [31:0] timeout_reg, absolute_reg, min_power_reg;
    logic [15:0] fraction_reg;
    logic [1:0]  early_mode_reg;

    // measurement state
    logic [2:0]  state_reg;
    logic [31:0] pw_last_reg, pw_period_reg, cv_last_reg, cv_period_reg;
    logic        pw_skip_reg, pw_ready_reg, cv_skip_reg, cv_ready_reg, mode_reg;
    logic [31:0] kp_reg [6];
    logic [31:0] sv_reg [3];
    logic [1:0]  stale_reg;
    logic [31:0] last_pub_reg;
    logic        first_reg, pub_reg;
    logic [31:0] now_reg;
    logic        out_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    pfpm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [1:0]  req_type;
    logic [31:0] time_us;
    assign req_type = s_tdata[1:0];
    assign time_us  = s_tdata[33:2];
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;

    // one-third window, no wrapping; the third comes from a reciprocal multiply
    function automatic logic within_third(input logic [31:0] c, input logic [31:0] p);
        logic [63:0] prod;
        logic [33:0] third;
        logic [33:0] hi;
        logic [33:0] lo;
        begin
            prod  = {32'h0, c} * 64'h0000_0000_AAAA_AAAB;
            third = {3'b000, prod[63:33]};
            hi    = {2'b00, c} + third;
            lo    = {2'b00, c} - third;
            within_third = !(({2'b00, p} < lo) || ({2'b00, p} > hi));
        end
    endfunction

    // publish decision against current state values
    logic pub_go, pub_first;
    always_comb
    begin
        pub_first = !first_reg;
        if (!first_reg)
            pub_go = 1'b0;
        else if (early_mode_reg == 2'd0)
            pub_go = 1'b1;
        else if (stale_reg == 2'b11)
            pub_go = 1'b1;
        else if (stale_reg[0] != stale_reg[1])
            pub_go = 1'b0;
        else
            pub_go = within_third(kp_reg[0], kp_reg[1]) &&
                     within_third(kp_reg[2], kp_reg[3]) &&
                     within_third(kp_reg[4], kp_reg[5]);
    end

    // early publish rules
    logic [48:0] frac_s, frac_hi, frac_lo;
    logic        frac_hit;
    logic [32:0] abs_hi;
    logic        abs_hit;
    always_comb
    begin
        frac_s   = {1'b0, sv_reg[0], 16'h0};
        frac_hi  = 49'(last_pub_reg * (33'h10000 + {17'h0, fraction_reg}));
        frac_lo  = 49'(last_pub_reg * (33'h10000 - {17'h0, fraction_reg}));
        frac_hit = early_mode_reg[0] && (last_pub_reg >= min_power_reg) &&
                   ((frac_s > frac_hi) || (frac_s < frac_lo));
        abs_hi   = {1'b0, last_pub_reg} + {1'b0, absolute_reg};
        abs_hit  = early_mode_reg[1] &&
                   (({1'b0, sv_reg[0]} > abs_hi) ||
                    ((last_pub_reg >= absolute_reg) &&
                     (sv_reg[0] < last_pub_reg - absolute_reg)));
    end

    logic cv_timeout, pw_timeout;
    assign cv_timeout = (now_reg - cv_last_reg) > timeout_reg;
    assign pw_timeout = (now_reg - pw_last_reg) > timeout_reg;

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = pw_scale_reg;
        dreq.divisor  = pw_period_reg;
        if (state_reg == ST_CV)
        begin
            dreq.start    = cv_ready_reg;
            dreq.dividend = mode_reg ? cur_scale_reg : vol_scale_reg;
            dreq.divisor  = cv_period_reg;
        end
        else if (state_reg == ST_PW)
            dreq.start = pw_ready_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_scale_reg   <= '0;
            cur_scale_reg  <= '0;
            vol_scale_reg  <= '0;
            timeout_reg    <= 32'd1000000;
            fraction_reg   <= '0;
            absolute_reg   <= '0;
            min_power_reg  <= '0;
            early_mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PW_SCALE:  pw_scale_reg   <= cfg_data;
                REG_CUR_SCALE: cur_scale_reg  <= cfg_data;
                REG_VOL_SCALE: vol_scale_reg  <= cfg_data;
                REG_TIMEOUT:   timeout_reg    <= cfg_data[31:0];
                REG_FRACTION:  fraction_reg   <= cfg_data[15:0];
                REG_ABSOLUTE:  absolute_reg   <= cfg_data[31:0];
                REG_MIN_POWER: min_power_reg  <= cfg_data[31:0];
                REG_MODE:      early_mode_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pw_last_reg   <= '0;
            pw_period_reg <= '0;
            cv_last_reg   <= '0;
            cv_period_reg <= '0;
            pw_skip_reg   <= 1'b1;
            pw_ready_reg  <= 1'b0;
            cv_skip_reg   <= 1'b1;
            cv_ready_reg  <= 1'b0;
            mode_reg      <= 1'b0;
            for (int i = 0; i < 6; i++) kp_reg[i] <= '0;
            for (int i = 0; i < 3; i++) sv_reg[i] <= '0;
            stale_reg     <= '0;
            last_pub_reg  <= '0;
            first_reg     <= 1'b0;
            pub_reg       <= 1'b0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        now_reg <= time_us;
                        pub_reg <= 1'b0;
                        case (req_type)
                            REQ_PW:
                            begin
                                pw_period_reg <= time_us - pw_last_reg;
                                pw_last_reg   <= time_us;
                                if (pw_skip_reg) pw_skip_reg <= 1'b0;
                                else pw_ready_reg <= 1'b1;
                                state_reg <= ST_OUT;
                            end
                            REQ_CV:
                            begin
                                cv_period_reg <= time_us - cv_last_reg;
                                cv_last_reg   <= time_us;
                                if (cv_skip_reg) cv_skip_reg <= 1'b0;
                                else cv_ready_reg <= 1'b1;
                                state_reg <= ST_OUT;
                            end
                            REQ_EVAL: state_reg <= ST_CV;
                            default:
                            begin
                                if (pub_first) first_reg <= 1'b1;
                                if (pub_go)
                                begin
                                    last_pub_reg <= sv_reg[0];
                                    pub_reg      <= 1'b1;
                                end
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_CV:
                begin
                    if (cv_ready_reg)
                        state_reg <= ST_CVW;
                    else
                    begin
                        if (cv_timeout)
                        begin
                            if (mode_reg)
                            begin
                                sv_reg[1]    <= '0;
                                stale_reg[1] <= 1'b1;
                            end
                            else
                                sv_reg[2] <= '0;
                            mode_reg      <= !mode_reg;
                            cv_skip_reg   <= 1'b1;
                            cv_last_reg   <= now_reg;
                            cv_period_reg <= '0;
                        end
                        state_reg <= ST_PW;
                    end
                end
                ST_CVW:
                begin
                    if (drsp.done)
                    begin
                        if (mode_reg)
                        begin
                            kp_reg[3]    <= kp_reg[2];
                            kp_reg[2]    <= cv_period_reg;
                            sv_reg[1]    <= drsp.value;
                            stale_reg[1] <= 1'b0;
                        end
                        else
                        begin
                            kp_reg[5] <= kp_reg[4];
                            kp_reg[4] <= cv_period_reg;
                            sv_reg[2] <= drsp.value;
                        end
                        mode_reg      <= !mode_reg;
                        cv_skip_reg   <= 1'b1;
                        cv_ready_reg  <= 1'b0;
                        cv_last_reg   <= now_reg;
                        cv_period_reg <= '0;
                        state_reg     <= ST_PW;
                    end
                end
                ST_PW:
                begin
                    if (pw_ready_reg)
                        state_reg <= ST_PWW;
                    else
                    begin
                        if (pw_timeout)
                        begin
                            sv_reg[0]    <= '0;
                            stale_reg[0] <= 1'b1;
                        end
                        state_reg <= ST_FRAC;
                    end
                end
                ST_PWW:
                begin
                    if (drsp.done)
                    begin
                        kp_reg[1]    <= kp_reg[0];
                        kp_reg[0]    <= pw_period_reg;
                        sv_reg[0]    <= drsp.value;
                        pw_ready_reg <= 1'b0;
                        stale_reg[0] <= 1'b0;
                        state_reg    <= ST_FRAC;
                    end
                end
                ST_FRAC, ST_ABS:
                begin
                    if ((state_reg == ST_FRAC) ? frac_hit : abs_hit)
                    begin
                        if (pub_first) first_reg <= 1'b1;
                        if (pub_go)
                        begin
                            last_pub_reg <= sv_reg[0];
                            pub_reg      <= 1'b1;
                        end
                    end
                    state_reg <= (state_reg == ST_FRAC) ? ST_ABS : ST_OUT;
                end
                default:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, stale_reg[1], stale_reg[0], sv_reg[2], sv_reg[1], sv_reg[0],
                       pub_reg, mode_reg};

    // a result is never raised while a request is in progress
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> state_reg == ST_IDLE) else $error("result during work");
    // an accepted request starts work, not a result
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid) else $error("early result");
    // no edge is pending on a channel that still skips
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        !(pw_skip_reg && pw_ready_reg)) else $error("power skip and ready");
    a_cvskip: assert property (@(posedge clk) disable iff (!rst_n)
        !(cv_skip_reg && cv_ready_reg)) else $error("cv skip and ready");
endmodule
